[rtl/pepd_pkg.sv]
// ---------------------------------------------------------------------------
// pepd_pkg
// Shared types, codes and the error pattern table of the error pattern
// event detector.
// ---------------------------------------------------------------------------
package pepd_pkg;

    localparam int ERROR_COUNT = 17;
    localparam int ERR_W       = 5;
    localparam int MOD_W       = 3;
    localparam int REGS_W      = 48;

    // item kinds
    localparam logic OP_COMPARE = 1'b0;
    localparam logic OP_MARK    = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MODULE = 2'd1;
    localparam logic [1:0] ST_BAD_ERROR  = 2'd2;

    typedef logic [ERROR_COUNT-1:0] flags_t;

    // error masks, bytes from low to high: R05, R06, R08, R09, R0A, R0B
    localparam logic [REGS_W-1:0] ERR_MASK [ERROR_COUNT] = '{
        48'h00_00_00_00_08_42,
        48'h00_00_00_00_04_22,
        48'h00_00_00_00_02_12,
        48'h00_00_00_00_01_0A,
        48'h00_00_00_00_00_04,
        48'h00_02_00_02_00_00,
        48'h00_00_00_00_80_42,
        48'h00_00_00_00_40_22,
        48'h00_00_00_00_20_12,
        48'h00_00_00_00_10_0A,
        48'h00_00_00_80_00_00,
        48'h00_02_10_00_00_00,
        48'h00_02_80_00_00_00,
        48'h00_02_20_00_00_00,
        48'h00_02_0F_00_00_00,
        48'hF0_02_00_00_00_00,
        48'h00_00_00_40_00_00
    };

    // one work unit handed from the update stage to the result emitter
    typedef struct packed {
        logic [MOD_W-1:0] module_index;
        logic [1:0]       status;
        flags_t           flags;
        flags_t           pending;
    } job_t;

    // one result word
    typedef struct packed {
        logic             event_valid;
        logic [MOD_W-1:0] event_module;
        logic [ERR_W-1:0] event_error;
        logic [1:0]       status;
        flags_t           active_errors;
        logic             last;
    } result_t;

    // set bit e when every mask bit of error e is present in the sample
    function automatic flags_t err_match(input logic [REGS_W-1:0] regs);
        flags_t hit;
        hit = '0;
        for (int e = 0; e < ERROR_COUNT; e++)
        begin
            hit[e] = ((regs & ERR_MASK[e]) == ERR_MASK[e]);
        end
        return hit;
    endfunction

    // index of a one-hot flag vector
    function automatic logic [ERR_W-1:0] onehot_index(input flags_t oh);
        logic [ERR_W-1:0] idx;
        idx = '0;
        for (int e = 0; e < ERROR_COUNT; e++)
        begin
            if (oh[e])
            begin
                idx = idx | ERR_W'(e);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/pepd_flag_store.sv]
// ---------------------------------------------------------------------------
// pepd_flag_store
// Reported flag memory, one row per module, with a registered read,
// per-row valid bits for reset and write-to-read forwarding.
// ---------------------------------------------------------------------------
module pepd_flag_store
    import pepd_pkg::*;
#(
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output flags_t            rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  flags_t            wdata
);

    flags_t     mem [DEPTH];
    flags_t     mem_rd_reg;
    logic [DEPTH-1:0] row_valid_reg;
    logic       rd_valid_reg;
    logic       fwd_reg;
    flags_t     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            mem_rd_reg   <= mem[raddr];
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                row_valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= row_valid_reg[raddr];
                fwd_reg      <= we && (waddr == raddr);
            end
        end
    end

    // rows never written read as zero
    assign rdata = fwd_reg      ? fwd_data_reg :
                   rd_valid_reg ? mem_rd_reg   : '0;

endmodule

[rtl/pepd_event_emit.sv]
// ---------------------------------------------------------------------------
// pepd_event_emit
// Hold one job and emit its result words, one new event per word in
// ascending error order or one word without an event, through a registered output.
// ---------------------------------------------------------------------------
module pepd_event_emit
    import pepd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    job_valid_reg;
    job_t    job_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_free;
    logic    emit;
    logic    done;
    flags_t  pick;
    flags_t  rest;
    result_t word_next;

    always_comb
    begin
        pick     = job_reg.pending & (~job_reg.pending + flags_t'(1));
        rest     = job_reg.pending & ~pick;
        out_free = !out_valid_reg || out_ready;
        emit     = job_valid_reg && out_free;
        done     = emit && (rest == '0);
        job_ready = !job_valid_reg || done;

        word_next.event_valid   = (job_reg.pending != '0);
        word_next.event_module  = job_reg.module_index;
        word_next.event_error   = onehot_index(pick);
        word_next.status        = job_reg.status;
        word_next.active_errors = job_reg.flags;
        word_next.last          = (rest == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && job_ready)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                job_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
        else if (emit)
        begin
            job_reg.pending <= rest;
        end
        if (emit)
        begin
            out_reg <= word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

[rtl/pmic_error_pattern_event_detector.sv]
// ---------------------------------------------------------------------------
// pmic_error_pattern_event_detector
// Compare power-controller error register samples against 17 error patterns
// and report each newly detected error once per module.
// ---------------------------------------------------------------------------
// Each input word either compares a sample of six error register bytes of one
// memory module against the 17 fixed patterns, or marks one error of a module
// as already reported. The reported flags live in a small memory, one 17-bit
// row per module, cleared by reset through per-row valid bits. An accepted
// word issues its registered row read on acceptance, the update stage computes
// the new row and writes it back while the next word's read is issued; a read
// of the row being written takes the written value. A compare word yields one
// result word per newly matched error (ascending error number, tlast on the
// final one) or a single word without event. Marks and invalid module or
// error numbers give one word. The first result passes the update stage,
// the emitter's job register and its output register. A word with one result
// sustains one word per cycle while the output is not stalled; a compare
// word with n new events gives n words, sent by the emitter one per cycle.
// ---------------------------------------------------------------------------
module pmic_error_pattern_event_detector
    import pepd_pkg::*;
#(
    parameter int MODULE_COUNT = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata: module_index[2:0], reg_r05[10:3], reg_r06[18:11],
    //               reg_r08[26:19], reg_r09[34:27], reg_r0a[42:35],
    //               reg_r0b[50:43], error_number[55:51]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    // s_axis_tuser: op[0]
    input  logic [0:0]  s_axis_tuser,
    // m_axis_tdata: event_valid[0], event_module[3:1], event_error[8:4],
    //               status[10:9], active_errors[27:11], zero[31:28]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int ADDR_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;

    // update stage: the accepted word, waiting for its flag row
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [MOD_W-1:0]  s1_mod_reg;
    logic [REGS_W-1:0] s1_regs_reg;
    logic [ERR_W-1:0]  s1_errn_reg;

    logic    s_accept;
    logic    s1_go;
    logic    job_ready;
    flags_t  cur_flags;
    flags_t  hit;
    flags_t  mark_bit;
    flags_t  new_flags;
    logic    mod_ok;
    logic    err_ok;
    logic    we;
    job_t    job;
    result_t out_word;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s1_go         = s1_valid_reg && job_ready;
    assign s_axis_tready = !s1_valid_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_op_reg   <= s_axis_tuser[0];
            s1_mod_reg  <= s_axis_tdata[2:0];
            s1_regs_reg <= s_axis_tdata[50:3];
            s1_errn_reg <= s_axis_tdata[55:51];
        end
    end

    pepd_flag_store #(
        .DEPTH  (MODULE_COUNT),
        .ADDR_W (ADDR_W)
    ) u_flag_store (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (s_accept),
        .raddr (s_axis_tdata[ADDR_W-1:0]),
        .rdata (cur_flags),
        .we    (we),
        .waddr (s1_mod_reg[ADDR_W-1:0]),
        .wdata (new_flags)
    );

    // compute the new row and the job for the emitter
    always_comb
    begin
        mod_ok   = ({1'b0, s1_mod_reg} < 4'(MODULE_COUNT));
        err_ok   = (s1_errn_reg < ERR_W'(ERROR_COUNT));
        hit      = err_match(s1_regs_reg);
        mark_bit = flags_t'(1) << s1_errn_reg;

        job.module_index = s1_mod_reg;
        job.pending      = '0;
        new_flags        = cur_flags;

        if (!mod_ok)
        begin
            job.status = ST_BAD_MODULE;
            job.flags  = '0;
        end
        else if (s1_op_reg == OP_MARK)
        begin
            if (err_ok)
            begin
                new_flags  = cur_flags | mark_bit;
                job.status = ST_OK;
            end
            else
            begin
                job.status = ST_BAD_ERROR;
            end
            job.flags = new_flags;
        end
        else
        begin
            // matched errors stay reported, the rest clear
            new_flags   = hit;
            job.status  = ST_OK;
            job.flags   = hit;
            job.pending = hit & ~cur_flags;
        end

        we = s1_go && mod_ok && ((s1_op_reg == OP_COMPARE) || err_ok);
    end

    pepd_event_emit u_event_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (s1_valid_reg),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {4'b0000, out_word.active_errors, out_word.status,
                           out_word.event_error, out_word.event_module,
                           out_word.event_valid};
    assign m_axis_tlast = out_word.last;

endmodule

[tb/pmic_error_pattern_event_detector_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pmic_error_pattern_event_detector_tb
// Self-checking bench for the power-controller error pattern event detector.
// ---------------------------------------------------------------------------
// Input words carry either a six-byte error register sample or a request to
// mark one error of a module as reported. A flag model kept in the bench
// predicts the result words of every accepted input word. Each result word
// that leaves the block is checked field by field against the oldest
// prediction. Traffic is a directed pass over the corner cases, random
// traffic built mostly from real error patterns, a long output stall that
// backs the block up, and pauses that drain it completely. Both sides idle
// at random between words, with calm stretches that do not idle at all.
// ---------------------------------------------------------------------------
module pmic_error_pattern_event_detector_tb;

    import pepd_pkg::*;

    localparam int MODULE_COUNT = 4;
    localparam int HOLD_CYCLES  = 400;

    // one expected result word, fields as the block reports them
    typedef struct {
        logic                   ev_valid;
        logic [MOD_W-1:0]       ev_module;
        logic [ERR_W-1:0]       ev_error;
        logic [1:0]             status;
        logic [ERROR_COUNT-1:0] active;
        logic                   last;
    } detect_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    // reported flags per module, as the block should hold them
    logic [ERROR_COUNT-1:0] flag_rows [MODULE_COUNT];
    // last sample sent to each module number, reused to repeat a steady state
    logic [47:0]            last_sample [8];
    detect_result_t         expected_words [$];

    int  mismatches      = 0;
    int  compare_words   = 0;
    int  mark_words      = 0;
    int  results_checked = 0;
    int  events_seen     = 0;
    int  rejects_seen    = 0;
    int  hold_off_cycles = 0;
    bit  tx_calm         = 1'b0;
    bit  rx_calm         = 1'b0;

    pmic_error_pattern_event_detector #(
        .MODULE_COUNT (MODULE_COUNT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // -----------------------------------------------------------------------
    // Error patterns, bytes from low to high: R05, R06, R08, R09, R0A, R0B.
    // An error matches when every one of its mask bits is set in the sample.
    // -----------------------------------------------------------------------
    function automatic logic [47:0] pattern_of(input int e);
        case (e)
            0:       return 48'h00_00_00_00_08_42;
            1:       return 48'h00_00_00_00_04_22;
            2:       return 48'h00_00_00_00_02_12;
            3:       return 48'h00_00_00_00_01_0A;
            4:       return 48'h00_00_00_00_00_04;
            5:       return 48'h00_02_00_02_00_00;
            6:       return 48'h00_00_00_00_80_42;
            7:       return 48'h00_00_00_00_40_22;
            8:       return 48'h00_00_00_00_20_12;
            9:       return 48'h00_00_00_00_10_0A;
            10:      return 48'h00_00_00_80_00_00;
            11:      return 48'h00_02_10_00_00_00;
            12:      return 48'h00_02_80_00_00_00;
            13:      return 48'h00_02_20_00_00_00;
            14:      return 48'h00_02_0F_00_00_00;
            15:      return 48'hF0_02_00_00_00_00;
            default: return 48'h00_00_00_40_00_00;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Work out the result words of one accepted input word and update the
    // flag model. Every result word of one compare carries the final flags.
    // -----------------------------------------------------------------------
    function automatic void predict_detection(input logic op, input logic [2:0] mod,
                                              input logic [47:0] regs,
                                              input logic [4:0] errn);
        detect_result_t         w;
        logic [ERROR_COUNT-1:0] row;
        logic [ERROR_COUNT-1:0] fresh;
        int                     total;
        int                     seen;
        w.ev_valid  = 1'b0;
        w.ev_module = mod;
        w.ev_error  = '0;
        w.status    = ST_OK;
        w.active    = '0;
        w.last      = 1'b1;
        // module number is checked first, for marks as well as compares
        if (mod >= MODULE_COUNT)
        begin
            w.status = ST_BAD_MODULE;
            expected_words.push_back(w);
            return;
        end
        if (op == OP_MARK)
        begin
            if (errn >= ERROR_COUNT)
                w.status = ST_BAD_ERROR;
            else
                flag_rows[mod][errn] = 1'b1;
            w.active = flag_rows[mod];
            expected_words.push_back(w);
            return;
        end
        row   = flag_rows[mod];
        fresh = '0;
        for (int e = 0; e < ERROR_COUNT; e++)
        begin
            if ((regs & pattern_of(e)) == pattern_of(e))
            begin
                if (!row[e])
                    fresh[e] = 1'b1;
                row[e] = 1'b1;
            end
            else
            begin
                row[e] = 1'b0;
            end
        end
        flag_rows[mod] = row;
        w.active       = row;
        total          = $countones(fresh);
        if (total == 0)
        begin
            expected_words.push_back(w);
            return;
        end
        // one event word per newly seen error, lowest error number first
        seen = 0;
        for (int e = 0; e < ERROR_COUNT; e++)
        begin
            if (fresh[e])
            begin
                seen++;
                w.ev_valid = 1'b1;
                w.ev_error = ERR_W'(e);
                w.last     = (seen == total);
                expected_words.push_back(w);
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Offer one word after a random gap and hold it until accepted. The
    // valid line stays high when the next word follows without a gap.
    // -----------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [2:0] mod,
                             input logic [47:0] regs, input logic [4:0] errn);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {errn, regs, mod};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_detection(op, mod, regs, errn);
        if (op == OP_MARK)
            mark_words++;
        else
            compare_words++;
    endtask

    // Drop valid and hold until every predicted word has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_words.size() != 0);
    endtask

    // OR of a few error patterns, sometimes with sparse noise or all bits set.
    function automatic logic [47:0] pattern_mix();
        logic [47:0] v;
        int          n;
        v = '0;
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            v |= pattern_of($urandom_range(0, ERROR_COUNT - 1));
        if ($urandom_range(0, 3) == 0)
            v |= 48'({$urandom, $urandom} & {$urandom, $urandom});
        if ($urandom_range(0, 15) == 0)
            v = '1;
        return v;
    endfunction

    // One random word: mostly compares on valid modules built from real
    // patterns, repeats of a module's last sample, near misses, plus marks,
    // bad module numbers and bad error numbers as noise.
    task automatic send_random_word();
        logic [2:0]  mod;
        logic [47:0] regs;
        logic [4:0]  errn;
        int          pick;
        mod = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(MODULE_COUNT, 7))
                                          : 3'($urandom_range(0, MODULE_COUNT - 1));
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            errn = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(ERROR_COUNT, 31))
                                               : 5'($urandom_range(0, ERROR_COUNT - 1));
            regs = 48'({$urandom, $urandom});
            send_word(OP_MARK, mod, regs, errn);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                regs = last_sample[mod];
            else if (pick < 70)
                regs = pattern_mix();
            else if (pick < 85)
                regs = pattern_mix() & ~(48'h1 << $urandom_range(0, 47));
            else
                regs = 48'({$urandom, $urandom});
            last_sample[mod] = regs;
            send_word(OP_COMPARE, mod, regs, 5'($urandom_range(0, 31)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Test tasks
    // -----------------------------------------------------------------------

    // Field extremes, every operation and every rejection path.
    task automatic test_directed();
        // empty sample, then everything at once, then the same again
        send_word(OP_COMPARE, 3'd0, 48'h0, 5'd0);
        send_word(OP_COMPARE, 3'd0, '1, 5'd31);
        send_word(OP_COMPARE, 3'd0, '1, 5'd0);
        // errors that go away clear their flags
        send_word(OP_COMPARE, 3'd0, 48'h0, 5'd31);
        // marks suppress later events, bad error numbers leave flags alone
        send_word(OP_MARK, 3'd1, 48'h0, 5'd0);
        send_word(OP_MARK, 3'd1, '1, 5'd16);
        send_word(OP_MARK, 3'd1, 48'h0, 5'd17);
        send_word(OP_MARK, 3'd1, 48'h0, 5'd31);
        send_word(OP_COMPARE, 3'd1, '1, 5'd0);
        // module numbers out of range, also with a bad error number
        send_word(OP_MARK, 3'd4, 48'h0, 5'd3);
        send_word(OP_MARK, 3'd7, '1, 5'd31);
        send_word(OP_COMPARE, 3'd7, '1, 5'd0);
        send_word(OP_COMPARE, 3'd5, 48'h0, 5'd0);
        // single pattern, a second one joining, the first one leaving
        send_word(OP_COMPARE, 3'd3, pattern_of(4), 5'd0);
        send_word(OP_COMPARE, 3'd3, pattern_of(4) | pattern_of(14), 5'd0);
        send_word(OP_COMPARE, 3'd3, pattern_of(14), 5'd0);
        // one bit short of a pattern matches nothing new
        send_word(OP_COMPARE, 3'd3, pattern_of(15) & ~48'h1000_0000_0000, 5'd0);
        send_word(OP_COMPARE, 3'd2, '1, 5'd31);
        send_word(OP_COMPARE, 3'd2, 48'h0, 5'd0);
    endtask

    // Random traffic in stretches; some stretches run without idling.
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            send_random_word();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Stall the output for a long stretch while input words keep coming,
    // so the block backs up and stalls its input.
    task automatic test_backpressure(input int count);
        hold_off_cycles = HOLD_CYCLES;
        tx_calm         = 1'b1;
        for (int i = 0; i < count; i++)
            send_random_word();
        tx_calm = 1'b0;
    endtask

    // Stop sending until every result is out, then resume.
    task automatic test_drain_pause(input int count);
        wait_drained();
        for (int i = 0; i < count; i++)
            send_random_word();
        wait_drained();
        for (int i = 0; i < count; i++)
            send_random_word();
    endtask

    // -----------------------------------------------------------------------
    // Stimulus: reset once, run the tests in turn, drain, report
    // -----------------------------------------------------------------------
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (int m = 0; m < MODULE_COUNT; m++)
            flag_rows[m] = '0;
        for (int m = 0; m < 8; m++)
            last_sample[m] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(320);
        test_backpressure(50);
        test_drain_pause(25);

        // everything is in; wait for the tail, then watch for stray words
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Covered %0d compare and %0d mark words over %0d modules.",
                 compare_words, mark_words, MODULE_COUNT);
        $display("Checked %0d result words: %0d events, %0d rejected requests.",
                 results_checked, events_seen, rejects_seen);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result side: a random pause before each word, calm stretches, and the
    // long hold-off that the backpressure test asks for.
    // -----------------------------------------------------------------------
    initial
    begin : result_sink
        int pause;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                m_axis_tready <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready && !rx_calm)
            begin
                pause = $urandom_range(0, 9);
                if (pause > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (pause) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Checker: compare each accepted result word with the oldest prediction
    // -----------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        detect_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: unexpected result word, expected none, actual %0h",
                             $time, m_axis_tdata);
            end
            else
            begin
                want = expected_words.pop_front();
                if (want.ev_valid)
                    events_seen++;
                if (want.status != ST_OK)
                    rejects_seen++;
                check_field("event_valid",   32'(want.ev_valid),  32'(m_axis_tdata[0]));
                check_field("event_module",  32'(want.ev_module), 32'(m_axis_tdata[3:1]));
                check_field("event_error",   32'(want.ev_error),  32'(m_axis_tdata[8:4]));
                check_field("status",        32'(want.status),    32'(m_axis_tdata[10:9]));
                check_field("active_errors", 32'(want.active),    32'(m_axis_tdata[27:11]));
                check_field("pad bits",      32'h0,               32'(m_axis_tdata[31:28]));
                check_field("last",          32'(want.last),      32'(m_axis_tlast));
            end
        end
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #5000000;
        $display("Timeout with %0d result words outstanding", expected_words.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/pepd_pkg.sv
rtl/pepd_flag_store.sv
rtl/pepd_event_emit.sv
rtl/pmic_error_pattern_event_detector.sv
tb/pmic_error_pattern_event_detector_tb.sv
